// ----- sv/ppt_pkg.sv -----
package ppt_pkg;

  localparam int ANGLE_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES    = 24;

  localparam logic CMD_BODY_TO_WORLD = 1'b0;
  localparam logic CMD_WORLD_TO_BODY = 1'b1;

  // 1/K of the CORDIC, Q2.30
  localparam logic signed [31:0] CORDIC_GAIN_Q30   = 32'sd652032874;
  localparam logic signed [31:0] QUARTER_TURN      = 32'sd1073741824;
  localparam logic signed [31:0] NEG_QUARTER_TURN  = -32'sd1073741824;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_yaw;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
  } result_t;

  typedef struct packed {
    logic               cmd;
    logic               flip;
    logic signed [32:0] a;
    logic signed [32:0] b;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cordic_t;

  typedef struct packed {
    logic               cmd;
    logic               flip;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [64:0] p_ac;
    logic signed [64:0] p_bs;
    logic signed [64:0] p_as;
    logic signed [64:0] p_bc;
  } prod_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [35:0] rx;
    logic signed [35:0] ry;
  } sum_t;

  // arctangent of 2^-i, 2^32 units per turn
  function automatic logic [31:0] ppt_atan(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] ppt_sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/ppt_cordic_step.sv -----
module ppt_cordic_step import ppt_pkg::*; #(
  parameter int          SHIFT = 0,
  parameter logic [31:0] ATAN  = 32'h20000000
) (
  input  cordic_t st_in,
  output cordic_t st_out
);

  logic signed [31:0] dx;
  logic signed [31:0] dy;

  always_comb begin
    dx = st_in.y >>> SHIFT;
    dy = st_in.x >>> SHIFT;
    st_out = st_in;
    // nonnegative residual turns counter-clockwise
    if (!st_in.z[31]) begin
      st_out.x = st_in.x - dx;
      st_out.y = st_in.y + dy;
      st_out.z = st_in.z - $signed(ATAN);
    end else begin
      st_out.x = st_in.x + dx;
      st_out.y = st_in.y - dy;
      st_out.z = st_in.z + $signed(ATAN);
    end
  end

endmodule

// ----- sv/planar_pose_transform.sv -----
// Planar rigid transform, body frame <-> world frame. Each word carries a point,
// a pose (x, y, yaw) and a direction bit; each produces one result word. The
// block is a pipeline that takes one word per clock when nothing is stalled and
// holds no state between words. Its stages are an input register, one register
// per CORDIC iteration for sine/cosine of the yaw, a product register (four
// 33x32 multipliers), a rounding register and the result register. Stalls only
// back up as far as the first empty stage, so bubbles are squeezed out and new
// words are taken while a result waits, as long as a stage is empty.
module planar_pose_transform import ppt_pkg::*; #(
  parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int ITER = (ANGLE_STEPS < ATAN_ENTRIES) ? ANGLE_STEPS : ATAN_ENTRIES;
  localparam int L    = ITER + 4;
  localparam int P_IN   = 0;
  localparam int P_PROD = ITER + 1;
  localparam int P_SUM  = ITER + 2;
  localparam int P_OUT  = ITER + 3;

  logic [L-1:0] v;
  logic [L-1:0] v_next;
  logic [L:0]   ld;

  item_t   inq;
  cordic_t prep;
  cordic_t cq [ITER];
  cordic_t cd [ITER];
  prod_t   pq;
  sum_t    sq;
  result_t outq;

  // a stage loads when empty or when its successor loads
  always_comb begin
    ld[L] = !result_stall;
    for (int k = L - 1; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
    v_next = ({v[L-2:0], item_valid} & ld[L-1:0]) | (v & ~ld[L-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  // no word is taken while in reset
  assign item_stall   = rst || !ld[P_IN];
  assign result_valid = v[P_OUT];
  assign result       = outq;

  always_ff @(posedge clk) begin
    if (ld[P_IN]) begin
      inq <= item;
    end
  end

  // angle setup: negate for world to body, fold beyond a quarter turn
  logic [31:0] ang;
  always_comb begin
    ang = {inq.pose_yaw, 16'h0000};
    if (inq.cmd == CMD_WORLD_TO_BODY) begin
      ang = 32'd0 - ang;
    end
    prep.cmd    = inq.cmd;
    prep.flip   = ($signed(ang) > QUARTER_TURN) || ($signed(ang) < NEG_QUARTER_TURN);
    prep.z      = prep.flip ? $signed({~ang[31], ang[30:0]}) : $signed(ang);
    prep.x      = CORDIC_GAIN_Q30;
    prep.y      = '0;
    prep.pose_x = inq.pose_x;
    prep.pose_y = inq.pose_y;
    if (inq.cmd == CMD_WORLD_TO_BODY) begin
      prep.a = 33'(inq.point_x) - 33'(inq.pose_x);
      prep.b = 33'(inq.point_y) - 33'(inq.pose_y);
    end else begin
      prep.a = 33'(inq.point_x);
      prep.b = 33'(inq.point_y);
    end
  end

  for (genvar k = 0; k < ITER; k++) begin : g_cordic
    ppt_cordic_step #(
      .SHIFT (k),
      .ATAN  (ppt_atan(k))
    ) u_step (
      .st_in  ((k == 0) ? prep : cq[(k == 0) ? 0 : k-1]),
      .st_out (cd[k])
    );

    always_ff @(posedge clk) begin
      if (ld[k+1]) begin
        cq[k] <= cd[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[P_PROD]) begin
      pq.cmd    <= cq[ITER-1].cmd;
      pq.flip   <= cq[ITER-1].flip;
      pq.pose_x <= cq[ITER-1].pose_x;
      pq.pose_y <= cq[ITER-1].pose_y;
      pq.p_ac   <= 65'(cq[ITER-1].a) * 65'(cq[ITER-1].x);
      pq.p_bs   <= 65'(cq[ITER-1].b) * 65'(cq[ITER-1].y);
      pq.p_as   <= 65'(cq[ITER-1].a) * 65'(cq[ITER-1].y);
      pq.p_bc   <= 65'(cq[ITER-1].b) * 65'(cq[ITER-1].x);
    end
  end

  // the half-turn fold negates cos and sin, i.e. both sums
  localparam logic signed [65:0] HALF_Q30 = 66'sd536870912;
  logic signed [65:0] sx;
  logic signed [65:0] sy;
  always_comb begin
    if (pq.flip) begin
      sx = 66'(pq.p_bs) - 66'(pq.p_ac) + HALF_Q30;
      sy = -66'(pq.p_as) - 66'(pq.p_bc) + HALF_Q30;
    end else begin
      sx = 66'(pq.p_ac) - 66'(pq.p_bs) + HALF_Q30;
      sy = 66'(pq.p_as) + 66'(pq.p_bc) + HALF_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[P_SUM]) begin
      sq.cmd    <= pq.cmd;
      sq.pose_x <= pq.pose_x;
      sq.pose_y <= pq.pose_y;
      sq.rx     <= sx[65:30];
      sq.ry     <= sy[65:30];
    end
  end

  logic signed [36:0] tx;
  logic signed [36:0] ty;
  always_comb begin
    tx = 37'(sq.rx);
    ty = 37'(sq.ry);
    if (sq.cmd == CMD_BODY_TO_WORLD) begin
      tx = tx + 37'(sq.pose_x);
      ty = ty + 37'(sq.pose_y);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[P_OUT]) begin
      outq.out_x <= ppt_sat32(tx);
      outq.out_y <= ppt_sat32(ty);
    end
  end

endmodule
